>>> design/slist_pkg.sv
// Shared definitions for the sorted list engine: list depth, derived widths,
// operation and status codes, and the control beat that drives every cell.
// Depends on nothing; used by slist_cell and sorted_list_engine.
package slist_pkg;

    localparam int DEPTH     = 32;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_OUT_RANGE = 2'd2
    } status_t;

    // Broadcast to every cell in the chain
    typedef struct packed {
        logic                     insert_en;
        logic                     remove_en;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

>>> design/sorted_list_engine.sv
// Top level of the sorted list engine: a chain of slist_cell instances, the
// entry count, the read select and the registered result beat.
// Depends on slist_pkg and slist_cell.
//
// A request is taken on any clock edge where start is high; busy is always
// low, so one request per cycle is sustained. All cells compare against the
// request value in parallel and shift in the same cycle, so the list and the
// count update at the accepting edge. The result appears in the cycle after,
// for exactly one cycle with done high; there is no way to stall it, so the
// receiver must capture it then. After reset the list is empty; no clearing
// pass is needed.
module sorted_list_engine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [slist_pkg::OP_W-1:0]           op,
    input  logic signed [slist_pkg::DATA_W-1:0]  value,
    input  logic [slist_pkg::IDX_W-1:0]          index,
    output logic                                 done,
    output logic signed [slist_pkg::DATA_W-1:0]  read_value,
    output logic                                 found,
    output logic [slist_pkg::STATUS_W-1:0]       status,
    output logic [slist_pkg::CNT_W-1:0]          count
);

    localparam int D = slist_pkg::DEPTH;

    logic [slist_pkg::CNT_W-1:0]  count_reg;
    logic [slist_pkg::CNT_W-1:0]  count_next;
    logic                         done_reg;
    logic signed [slist_pkg::DATA_W-1:0] read_value_reg;
    logic signed [slist_pkg::DATA_W-1:0] read_value_next;
    logic                         found_reg;
    logic                         found_next;
    slist_pkg::status_t           status_reg;
    slist_pkg::status_t           status_next;

    slist_pkg::cell_ctl_t         ctl;
    logic [D-1:0]                 lt_bus;
    logic [D-1:0]                 eq_bus;
    logic [D-1:0][slist_pkg::DATA_W-1:0] entry_bus;
    logic                         full;
    logic                         match_any;
    logic                         in_range;
    slist_pkg::op_t               op_code;

    assign busy      = 1'b0;
    assign op_code   = slist_pkg::op_t'(op);
    assign full      = (count_reg == slist_pkg::CNT_W'(D));
    assign match_any = |eq_bus;
    assign in_range  = (slist_pkg::CNT_W'(index) < count_reg);

    // Broadcast the request to the chain
    always_comb
    begin
        ctl.value     = value;
        ctl.insert_en = start && (op_code == slist_pkg::OP_INSERT) && !full;
        ctl.remove_en = start && (op_code == slist_pkg::OP_REMOVE) && match_any;
    end

    // Build the chain; the head sees the value on its left, the tail itself
    // on its right
    genvar gi;
    generate
        for (gi = 0; gi < D; gi++)
        begin : g_cell
            logic                                left_lt_w;
            logic signed [slist_pkg::DATA_W-1:0] left_w;
            logic signed [slist_pkg::DATA_W-1:0] right_w;
            logic                                occ_w;

            assign occ_w = (slist_pkg::CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_lt_w = 1'b1;
                assign left_w    = value;
            end
            else
            begin : g_body
                assign left_lt_w = lt_bus[gi-1];
                assign left_w    = entry_bus[gi-1];
            end

            if (gi == D - 1)
            begin : g_tail
                assign right_w = entry_bus[gi];
            end
            else
            begin : g_mid
                assign right_w = entry_bus[gi+1];
            end

            slist_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (occ_w),
                .left_lt     (left_lt_w),
                .left_entry  (left_w),
                .right_entry (right_w),
                .lt          (lt_bus[gi]),
                .eq          (eq_bus[gi]),
                .entry       (entry_bus[gi])
            );
        end
    endgenerate

    // Advance the entry count
    always_comb
    begin
        count_next = count_reg;
        if (ctl.insert_en)
        begin
            count_next = count_reg + slist_pkg::CNT_W'(1);
        end
        else if (ctl.remove_en)
        begin
            count_next = count_reg - slist_pkg::CNT_W'(1);
        end
    end

    // Form the result beat
    always_comb
    begin
        read_value_next = '0;
        found_next      = 1'b0;
        status_next     = slist_pkg::ST_OK;
        case (op_code)
            slist_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status_next = slist_pkg::ST_FULL;
                end
            end
            slist_pkg::OP_REMOVE,
            slist_pkg::OP_CONTAINS:
            begin
                found_next = match_any;
            end
            slist_pkg::OP_READ:
            begin
                if (in_range)
                begin
                    read_value_next = entry_bus[index];
                end
                else
                begin
                    status_next = slist_pkg::ST_OUT_RANGE;
                end
            end
            default:
            begin
                status_next = slist_pkg::ST_OK;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    // Hold the result payload for its beat
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            read_value_reg <= read_value_next;
            found_reg      <= found_next;
            status_reg     <= status_next;
        end
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign found      = found_reg;
    assign status     = status_reg;
    assign count      = count_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= slist_pkg::CNT_W'(D))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (op_code == slist_pkg::OP_INSERT) && !full)
        |=> (count_reg == $past(count_reg) + slist_pkg::CNT_W'(1)))
        else $error("insert did not grow the list");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == slist_pkg::ST_FULL))
        |-> (full && !found_reg))
        else $error("full flag without a full list");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (op_code == slist_pkg::OP_REMOVE) && match_any)
        |=> (found_reg && (count_reg == $past(count_reg) - slist_pkg::CNT_W'(1))))
        else $error("remove did not shrink the list");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == slist_pkg::ST_OUT_RANGE))
        |-> (read_value_reg == '0))
        else $error("out of range read returned data");

endmodule

>>> design/slist_cell.sv
// One cell of the sorted list chain: holds a single entry, compares it with
// the broadcast value and shifts toward its left or right neighbor.
// Depends on slist_pkg.
module slist_cell (
    input  logic                               clk,
    input  slist_pkg::cell_ctl_t               ctl,
    input  logic                               occupied,
    input  logic                               left_lt,
    input  logic signed [slist_pkg::DATA_W-1:0] left_entry,
    input  logic signed [slist_pkg::DATA_W-1:0] right_entry,
    output logic                               lt,
    output logic                               eq,
    output logic signed [slist_pkg::DATA_W-1:0] entry
);

    logic signed [slist_pkg::DATA_W-1:0] entry_reg;
    logic signed [slist_pkg::DATA_W-1:0] entry_next;

    // Compare held entry against the broadcast value
    assign lt    = occupied && (entry_reg < ctl.value);
    assign eq    = occupied && (entry_reg == ctl.value);
    assign entry = entry_reg;

    // Take the new value at the insert point, shift right past it,
    // or pull from the right at and after the removed entry
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert_en && !lt)
        begin
            entry_next = left_lt ? ctl.value : left_entry;
        end
        else if (ctl.remove_en && !lt)
        begin
            entry_next = right_entry;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
